>>> hdl/cgl_pkg.sv
// Shared constants, types and register codes for the color gradient lookup.
package cgl_pkg;

    // Register file layout
    localparam int REG_STOPS  = 4;
    localparam int CNT_W      = 3;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 2;

    // Parameter defaults
    localparam int NUM_STOPS_DEF   = 4;
    localparam int SAMPLE_BITS_DEF = 16;

    // Datapath widths
    localparam int POS_W    = 16;
    localparam int COLOR_W  = 24;
    localparam int CHAN_W   = 8;
    localparam int NUM_CH   = 3;
    localparam int PROD_W   = CHAN_W + POS_W;    // channel times distance
    localparam int NUM_W    = PROD_W + 2;        // 2*num + d
    localparam int DEN_W    = POS_W + 1;         // 2*d
    localparam int QUO_W    = CHAN_W;            // one divider stage per quotient bit

    // Pipeline stage counts
    localparam int SEG_STAGES   = 2;
    localparam int BLEND_STAGES = 2;
    localparam int LATENCY      = SEG_STAGES + BLEND_STAGES + QUO_W;

    typedef logic [POS_W-1:0]   t_pos;
    typedef logic [COLOR_W-1:0] t_color;
    typedef logic [CHAN_W-1:0]  t_chan;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STOP_COUNT     = 2'd0,
        CFG_STOP_POSITIONS = 2'd1,
        CFG_COLORS_LOW     = 2'd2,
        CFG_COLORS_HIGH    = 2'd3
    } t_cfg_idx;

    // Selected segment: offset, span and end colors
    typedef struct packed {
        t_pos   n;
        t_pos   d;
        t_color c0;
        t_color c1;
        logic   ok;
    } t_seg;

    // Per-channel rounding fractions for the divider
    typedef struct packed {
        logic [NUM_CH-1:0][NUM_W-1:0] num;
        logic [DEN_W-1:0]             den;
        logic                         ok;
    } t_frac;

endpackage

>>> hdl/cgl_seg.sv
// Segment search: compares the sample to every stop and picks the blend segment.
module cgl_seg #(
    parameter int SAMPLE_BITS = cgl_pkg::SAMPLE_BITS_DEF,
    parameter int NUM_STOPS   = cgl_pkg::NUM_STOPS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_en,
    input  logic [SAMPLE_BITS-1:0]                       i_sample,
    input  logic [cgl_pkg::CNT_W-1:0]                    i_cnt,
    input  cgl_pkg::t_pos   [cgl_pkg::REG_STOPS-1:0]     i_pos,
    input  cgl_pkg::t_color [cgl_pkg::REG_STOPS-1:0]     i_color,
    output cgl_pkg::t_seg                                o_seg
);
    import cgl_pkg::*;

    localparam int USED  = (NUM_STOPS < REG_STOPS) ? NUM_STOPS : REG_STOPS;
    localparam int CMP_W = (SAMPLE_BITS > POS_W) ? SAMPLE_BITS : POS_W;

    logic [CMP_W-1:0] s_ext;
    logic [USED-1:0]  n_ge;
    logic [CMP_W-1:0] r_sample;
    logic [USED-1:0]  r_ge;

    logic   seg_found;
    t_pos   seg_p0;
    t_pos   seg_p1;
    t_color seg_c0;
    t_color seg_c1;
    logic   last_ge;
    t_color last_c;
    t_color fb_c;
    t_seg   n_seg;
    t_seg   r_seg;

    // Stage 1: sample against every stop position
    assign s_ext = CMP_W'(i_sample);

    always_comb begin
        for (int i = 0; i < USED; i++) begin
            n_ge[i] = s_ext >= CMP_W'(i_pos[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sample <= s_ext;
            r_ge     <= n_ge;
        end
    end

    // Stage 2: first segment with lower <= sample < upper, else end-stop fallback
    always_comb begin
        seg_found = 1'b0;
        seg_p0    = '0;
        seg_p1    = '0;
        seg_c0    = i_color[0];
        seg_c1    = i_color[0];
        last_ge   = 1'b0;
        last_c    = i_color[0];
        for (int i = 0; i < USED - 1; i++) begin
            if (!seg_found && (i + 1 < int'(i_cnt)) && r_ge[i] && !r_ge[i+1]) begin
                seg_found = 1'b1;
                seg_p0    = i_pos[i];
                seg_p1    = i_pos[i+1];
                seg_c0    = i_color[i];
                seg_c1    = i_color[i+1];
            end
        end
        for (int i = 0; i < USED; i++) begin
            if (i == int'(i_cnt) - 1) begin
                last_ge = r_ge[i];
                last_c  = i_color[i];
            end
        end
        fb_c = last_ge ? last_c : i_color[0];
        if (i_cnt == '0) begin
            fb_c = '0;
        end

        n_seg.ok = i_cnt != '0;
        if (seg_found) begin
            n_seg.n  = r_sample[POS_W-1:0] - seg_p0;
            n_seg.d  = seg_p1 - seg_p0;
            n_seg.c0 = seg_c0;
            n_seg.c1 = seg_c1;
        end else begin
            // flat color as a one-step blend: n = 0, d = 1
            n_seg.n  = '0;
            n_seg.d  = POS_W'(1);
            n_seg.c0 = fb_c;
            n_seg.c1 = fb_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_seg <= n_seg;
        end
    end

    assign o_seg = r_seg;

endmodule

>>> hdl/cgl_blend.sv
// Blend numerators: channel weights times distances, then rounded dividend and divisor.
module cgl_blend (
    input  logic           i_clk,
    input  logic           i_en,
    input  cgl_pkg::t_seg  i_seg,
    output cgl_pkg::t_frac o_frac
);
    import cgl_pkg::*;

    logic [NUM_CH-1:0][PROD_W-1:0] n_lo;
    logic [NUM_CH-1:0][PROD_W-1:0] n_hi;
    logic [NUM_CH-1:0][PROD_W-1:0] r_lo;
    logic [NUM_CH-1:0][PROD_W-1:0] r_hi;
    t_pos                          r_d;
    logic                          r_ok;
    logic [NUM_CH-1:0][PROD_W-1:0] sum;
    t_pos                          d_minus_n;
    t_frac                         n_frac;
    t_frac                         r_frac;

    // Stage 3: c0*(d-n) and c1*n per channel
    assign d_minus_n = i_seg.d - i_seg.n;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            n_lo[c] = PROD_W'(i_seg.c0[CHAN_W*c +: CHAN_W]) * PROD_W'(d_minus_n);
            n_hi[c] = PROD_W'(i_seg.c1[CHAN_W*c +: CHAN_W]) * PROD_W'(i_seg.n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
            r_d  <= i_seg.d;
            r_ok <= i_seg.ok;
        end
    end

    // Stage 4: dividend 2*num + d, divisor 2*d (round half up)
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            sum[c]        = r_lo[c] + r_hi[c];
            n_frac.num[c] = NUM_W'({sum[c], 1'b0}) + NUM_W'(r_d);
        end
        n_frac.den = {r_d, 1'b0};
        n_frac.ok  = r_ok;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_frac <= n_frac;
        end
    end

    assign o_frac = r_frac;

endmodule

>>> hdl/cgl_div.sv
// Pipelined restoring divider: one quotient bit per stage, 8-bit quotient.
module cgl_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [cgl_pkg::NUM_W-1:0] i_num,
    input  logic [cgl_pkg::DEN_W-1:0] i_den,
    output cgl_pkg::t_chan            o_quo
);
    import cgl_pkg::*;

    logic [NUM_W-1:0] r_rem [QUO_W-1];
    logic [DEN_W-1:0] r_den [QUO_W-1];
    logic [QUO_W-1:0] r_q   [QUO_W];

    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] q_in;
        logic [NUM_W-1:0] trial;
        logic             take;
        logic [QUO_W-1:0] n_q;

        if (j == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign q_in   = r_q[j-1];
        end

        // try divisor shifted to this quotient bit
        assign trial = NUM_W'(den_in) << (QUO_W - 1 - j);
        assign take  = rem_in >= trial;
        assign n_q   = q_in | (QUO_W'(take) << (QUO_W - 1 - j));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[j] <= n_q;
            end
        end

        if (j < QUO_W - 1) begin : g_carry
            logic [NUM_W-1:0] n_rem;
            assign n_rem = take ? (rem_in - trial) : rem_in;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= n_rem;
                    r_den[j] <= den_in;
                end
            end
        end
    end

    assign o_quo = r_q[QUO_W-1];

endmodule

>>> hdl/color_gradient_lookup.sv
// Pipeline: 2 search, 2 blend and 8 divider stages between input transfer and result.
// Throughput: one sample per cycle unless the result side stalls; the 8-stage divider per channel sets the depth.
// A stall on the result side freezes every stage together, so nothing is lost or repeated.
// Reset (synchronous, active low) clears the stage valid bits and all configuration
// registers; payload registers are not reset.
// Top level: configuration registers, pipeline control and the blend datapath.
module color_gradient_lookup #(
    parameter int NUM_STOPS   = cgl_pkg::NUM_STOPS_DEF,
    parameter int SAMPLE_BITS = cgl_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [SAMPLE_BITS-1:0]        i_sample,
    // color channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [cgl_pkg::CHAN_W-1:0]    o_red,
    output logic [cgl_pkg::CHAN_W-1:0]    o_green,
    output logic [cgl_pkg::CHAN_W-1:0]    o_blue,
    output logic                          o_color_valid,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [cgl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cgl_pkg::CFG_W-1:0]     i_cfg_data
);
    import cgl_pkg::*;

    localparam int USED     = (NUM_STOPS < REG_STOPS) ? NUM_STOPS : REG_STOPS;
    localparam int COLS_W   = 2 * COLOR_W;

    logic [CNT_W-1:0]           r_stop_count;
    logic [REG_STOPS*POS_W-1:0] r_positions;
    logic [COLS_W-1:0]          r_colors_low;
    logic [COLS_W-1:0]          r_colors_high;

    logic [CNT_W-1:0]           eff_cnt;
    t_pos   [REG_STOPS-1:0]     stop_pos;
    t_color [REG_STOPS-1:0]     stop_col;

    logic                       pipe_en;
    logic [LATENCY-1:0]         r_vld;
    logic [QUO_W-1:0]           r_ok;
    t_seg                       seg;
    t_frac                      frac;
    t_chan  [NUM_CH-1:0]        quo;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_count  <= '0;
            r_positions   <= '0;
            r_colors_low  <= '0;
            r_colors_high <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_STOP_COUNT:     r_stop_count  <= i_cfg_data[CNT_W-1:0];
                CFG_STOP_POSITIONS: r_positions   <= i_cfg_data[REG_STOPS*POS_W-1:0];
                CFG_COLORS_LOW:     r_colors_low  <= i_cfg_data[COLS_W-1:0];
                CFG_COLORS_HIGH:    r_colors_high <= i_cfg_data[COLS_W-1:0];
                default: ;
            endcase
        end
    end

    // Stop count clamped to the stops that exist
    assign eff_cnt  = (r_stop_count > CNT_W'(USED)) ? CNT_W'(USED) : r_stop_count;
    assign stop_pos = r_positions;
    assign stop_col = {r_colors_high, r_colors_low};

    // Pipeline control: all stages advance unless the result is held
    assign pipe_en = !r_vld[LATENCY-1] || i_ready;
    assign o_ready = pipe_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[LATENCY-2:0], i_valid};
        end
    end

    // color_valid rides alongside the divider stages
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_ok <= {r_ok[QUO_W-2:0], frac.ok};
        end
    end

    cgl_seg #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .NUM_STOPS   (NUM_STOPS)
    ) u_seg (
        .i_clk    (i_clk),
        .i_en     (pipe_en),
        .i_sample (i_sample),
        .i_cnt    (eff_cnt),
        .i_pos    (stop_pos),
        .i_color  (stop_col),
        .o_seg    (seg)
    );

    cgl_blend u_blend (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_seg  (seg),
        .o_frac (frac)
    );

    for (genvar c = 0; c < NUM_CH; c++) begin : g_chan
        cgl_div u_div (
            .i_clk (i_clk),
            .i_en  (pipe_en),
            .i_num (frac.num[c]),
            .i_den (frac.den),
            .o_quo (quo[c])
        );
    end

    // Result
    assign o_valid       = r_vld[LATENCY-1];
    assign o_red         = quo[2];
    assign o_green       = quo[1];
    assign o_blue        = quo[0];
    assign o_color_valid = r_ok[QUO_W-1];

    // Selected segment always has a nonzero span and an offset inside it
    a_seg_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[SEG_STAGES-1] |-> (seg.d != '0) && (seg.n < seg.d))
        else $error("segment span or offset out of range");

    // No stops: a result carries black and no color
    a_no_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && eff_cnt == '0) |-> (!o_color_valid && o_red == '0 &&
                                        o_green == '0 && o_blue == '0))
        else $error("result with no stops is not empty");

    // One stop: every result is that stop's color
    a_one_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && eff_cnt == CNT_W'(1)) |-> (o_color_valid &&
                                               {o_red, o_green, o_blue} == stop_col[0]))
        else $error("single stop result differs from its color");

endmodule

>>> verif/color_gradient_lookup_tb.sv
// Self-checking testbench for color_gradient_lookup against a gradient predictor.
module color_gradient_lookup_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cgl_pkg::*;

    localparam int RANDOM_PHASES    = 11;
    localparam int PHASE_ITEMS      = 150;
    localparam int QUIET_FROM       = 1500;
    localparam int LONG_HOLD_AT     = 400;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int STALL_LIMIT      = 1000;
    localparam int MAX_REPORTS      = 40;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
        logic  color_valid;
    } t_rgb_result;

    // DUT ports, all inputs known from time zero
    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_valid       = 1'b0;
    logic                       o_ready;
    logic [SAMPLE_BITS_DEF-1:0] i_sample      = '0;
    logic                       o_valid;
    logic                       i_ready       = 1'b0;
    logic [CHAN_W-1:0]          o_red;
    logic [CHAN_W-1:0]          o_green;
    logic [CHAN_W-1:0]          o_blue;
    logic                       o_color_valid;
    logic                       i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index   = '0;
    logic [CFG_W-1:0]           i_cfg_data    = '0;

    // Shadow copy of the gradient registers
    logic [CNT_W-1:0] cfg_count     = '0;
    logic [63:0]      cfg_positions = '0;
    logic [47:0]      cfg_colors_lo = '0;
    logic [47:0]      cfg_colors_hi = '0;

    t_pos        pending_samples[$];
    t_rgb_result expected_colors[$];
    t_rgb_result want;

    int samples_sent   = 0;
    int colors_seen    = 0;
    int mismatches     = 0;
    int settings_used  = 0;
    int gap_left       = 0;
    int ready_hold     = 0;
    int idle_cycles    = 0;
    bit long_hold_done = 1'b0;

    color_gradient_lookup dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_color_valid (o_color_valid),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_pos stop_pos(int idx);
        return cfg_positions[16*idx +: 16];
    endfunction

    function automatic t_color stop_color(int idx);
        return (idx < 2) ? cfg_colors_lo[24*idx +: 24] : cfg_colors_hi[24*(idx-2) +: 24];
    endfunction

    // Exact linear blend, rounded half up
    function automatic t_chan blend_channel(t_chan c0, t_chan c1, t_pos n, t_pos d);
        logic [63:0] weighted;
        weighted = 64'(c0) * (64'(d) - 64'(n)) + 64'(c1) * 64'(n);
        return t_chan'((2 * weighted + 64'(d)) / (2 * 64'(d)));
    endfunction

    // Expected color for one sample under the current gradient
    function automatic t_rgb_result gradient_color(t_pos s);
        int          used;
        int          i;
        logic        hit;
        t_pos        p0;
        t_pos        p1;
        t_color      c0;
        t_color      c1;
        t_color      color;
        t_rgb_result r;
        r    = '0;
        used = int'(cfg_count);
        if (used > NUM_STOPS_DEF) used = NUM_STOPS_DEF;
        if (used > REG_STOPS) used = REG_STOPS;
        if (used == 0) return r;
        hit   = 1'b0;
        color = stop_color(0);
        for (i = 0; i + 1 < used; i++) begin
            p0 = stop_pos(i);
            p1 = stop_pos(i + 1);
            if (!hit && s >= p0 && s < p1) begin
                c0    = stop_color(i);
                c1    = stop_color(i + 1);
                color = {blend_channel(c0[23:16], c1[23:16], s - p0, p1 - p0),
                         blend_channel(c0[15:8],  c1[15:8],  s - p0, p1 - p0),
                         blend_channel(c0[7:0],   c1[7:0],   s - p0, p1 - p0)};
                hit   = 1'b1;
            end
        end
        // outside every segment: last color at or above the last stop, else the first color
        if (!hit && s >= stop_pos(used - 1)) color = stop_color(used - 1);
        r.red         = color[23:16];
        r.green       = color[15:8];
        r.blue        = color[7:0];
        r.color_valid = 1'b1;
        return r;
    endfunction

    // Random sample, biased toward stop edges and the range ends
    function automatic t_pos pick_sample();
        int unsigned kind;
        kind = $urandom_range(0, 7);
        if (kind <= 3) return t_pos'($urandom);
        if (kind <= 6) return stop_pos($urandom_range(0, 3)) + t_pos'($urandom_range(0, 4)) - 16'd2;
        return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at color %0d: %s", colors_seen, what);
    endtask

    // Single register write; the shadow copy follows at the write edge
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_STOP_COUNT:     cfg_count     = data[CNT_W-1:0];
            CFG_STOP_POSITIONS: cfg_positions = data;
            CFG_COLORS_LOW:     cfg_colors_lo = data[47:0];
            CFG_COLORS_HIGH:    cfg_colors_hi = data[47:0];
            default: ;
        endcase
    endtask

    // Sender pause: hold off until every queued sample has its color back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_samples.size() != 0 || i_valid || expected_colors.size() != 0);
        repeat (LATENCY) @(posedge i_clk);
        settings_used++;
    endtask

    // Sample driver: one transfer per handshake, random gaps until the quiet tail
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left <= 0;
        end else if (!i_valid || o_ready) begin
            if (gap_left != 0) begin
                i_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_samples.size() == 0) begin
                i_valid <= 1'b0;
            end else if (samples_sent < QUIET_FROM && $urandom_range(0, 5) == 0) begin
                i_valid  <= 1'b0;
                gap_left <= $urandom_range(0, 4);
            end else begin
                i_valid      <= 1'b1;
                i_sample     <= pending_samples.pop_front();
                samples_sent <= samples_sent + 1;
            end
        end
    end

    // Color monitor, receiver stalls and watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready     <= 1'b0;
            ready_hold  <= 0;
            idle_cycles <= 0;
        end else begin
            // check each color transfer against the oldest prediction
            if (o_valid && i_ready) begin
                if (expected_colors.size() == 0) begin
                    report_mismatch("color transfer with no sample outstanding");
                end else begin
                    want = expected_colors.pop_front();
                    if (o_red !== want.red)
                        report_mismatch($sformatf("red %02h, expected %02h", o_red, want.red));
                    if (o_green !== want.green)
                        report_mismatch($sformatf("green %02h, expected %02h",
                                                  o_green, want.green));
                    if (o_blue !== want.blue)
                        report_mismatch($sformatf("blue %02h, expected %02h", o_blue, want.blue));
                    if (o_color_valid !== want.color_valid)
                        report_mismatch($sformatf("color_valid %b, expected %b",
                                                  o_color_valid, want.color_valid));
                end
                colors_seen <= colors_seen + 1;
            end

            // predict on each sample transfer
            if (i_valid && o_ready)
                expected_colors.push_back(gradient_color(i_sample));

            // ready: one long hold to back up the pipe, short random bursts otherwise
            if (ready_hold != 0) begin
                i_ready    <= 1'b0;
                ready_hold <= ready_hold - 1;
            end else if (!long_hold_done && colors_seen >= LONG_HOLD_AT) begin
                i_ready        <= 1'b0;
                ready_hold     <= LONG_HOLD_CYCLES - 1;
                long_hold_done <= 1'b1;
            end else if (colors_seen < QUIET_FROM && $urandom_range(0, 5) == 0) begin
                i_ready    <= 1'b0;
                ready_hold <= $urandom_range(0, 4);
            end else begin
                i_ready <= 1'b1;
            end

            // watchdog on cycles without any transfer
            if ((o_valid && i_ready) || (i_valid && o_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles == STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("color_gradient_lookup_tb: FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Stimulus: directed gradients first, then random gradients and samples
    initial begin
        int          phase;
        int          k;
        int          m;
        int unsigned shape;
        int unsigned pick;
        int unsigned base;
        logic [2:0]  count;
        t_pos        pos[4];
        t_pos        swap;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no stops after reset: color_valid stays low
        @(negedge i_clk);
        pending_samples.push_back(16'h0000);
        pending_samples.push_back(16'hFFFF);
        wait_drained();

        // one stop: its own color everywhere; upper count bits are don't-care
        write_reg(CFG_STOP_COUNT, 64'hFFFF_FFFF_FFFF_FFF9);
        write_reg(CFG_COLORS_LOW, 64'hA5A5_00FF_0012_AB7F);
        @(negedge i_clk);
        pending_samples.push_back(16'h0000);
        pending_samples.push_back(16'hFFFF);
        wait_drained();

        // four stops spanning the full range, extreme channel values
        write_reg(CFG_STOP_COUNT, 64'd4);
        write_reg(CFG_STOP_POSITIONS, 64'hFFFF_C000_4000_0000);
        write_reg(CFG_COLORS_LOW, 64'h0000_FFFF_FF00_0000);
        write_reg(CFG_COLORS_HIGH, 64'hFFFF_FF00_FF00_FF00);
        @(negedge i_clk);
        pending_samples.push_back(16'h0000);
        pending_samples.push_back(16'h3FFF);
        pending_samples.push_back(16'h4000);
        pending_samples.push_back(16'h8000);
        pending_samples.push_back(16'hBFFF);
        pending_samples.push_back(16'hC000);
        pending_samples.push_back(16'hFFFE);
        pending_samples.push_back(16'hFFFF);
        wait_drained();

        // equal adjacent positions: those segments never match
        write_reg(CFG_STOP_POSITIONS, 64'h8000_8000_1000_1000);
        @(negedge i_clk);
        pending_samples.push_back(16'h0FFF);
        pending_samples.push_back(16'h1000);
        pending_samples.push_back(16'h7FFF);
        pending_samples.push_back(16'h8000);
        pending_samples.push_back(16'hFFFF);
        wait_drained();

        // count above four is clamped; unit-width segments
        write_reg(CFG_STOP_COUNT, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_STOP_POSITIONS, 64'h0103_0102_0101_0100);
        @(negedge i_clk);
        pending_samples.push_back(16'h00FF);
        pending_samples.push_back(16'h0100);
        pending_samples.push_back(16'h0101);
        pending_samples.push_back(16'h0102);
        pending_samples.push_back(16'h0103);
        wait_drained();

        // unsorted positions with three stops
        write_reg(CFG_STOP_COUNT, 64'd3);
        write_reg(CFG_STOP_POSITIONS, 64'h0000_A000_2000_8000);
        @(negedge i_clk);
        pending_samples.push_back(16'h1000);
        pending_samples.push_back(16'h2000);
        pending_samples.push_back(16'h8000);
        pending_samples.push_back(16'hA000);
        wait_drained();

        // random gradients, mostly sorted, some with ties, tight spans or disorder
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            for (k = 0; k < 4; k++) pos[k] = t_pos'($urandom);
            shape = $urandom_range(0, 9);
            if (shape == 8) begin
                base = $urandom_range(0, 65000);
                for (k = 0; k < 4; k++) pos[k] = t_pos'(base + $urandom_range(0, 6));
            end
            if (shape == 9) begin
                pos[0] = 16'h0000;
                pos[3] = 16'hFFFF;
            end
            if (shape != 7) begin
                for (k = 0; k < 3; k++) begin
                    for (m = 0; m < 3 - k; m++) begin
                        if (pos[m] > pos[m+1]) begin
                            swap     = pos[m];
                            pos[m]   = pos[m+1];
                            pos[m+1] = swap;
                        end
                    end
                end
            end
            if (shape == 6) begin
                k = $urandom_range(0, 2);
                pos[k+1] = pos[k];
            end

            pick = $urandom_range(0, 15);
            if (pick == 0)       count = 3'd0;
            else if (pick == 1)  count = 3'd1;
            else if (pick <= 3)  count = 3'd2;
            else if (pick <= 5)  count = 3'd3;
            else if (pick <= 13) count = 3'd4;
            else                 count = 3'($urandom_range(5, 7));

            write_reg(CFG_STOP_COUNT, {$urandom, 29'($urandom), count});
            write_reg(CFG_STOP_POSITIONS, {pos[3], pos[2], pos[1], pos[0]});
            write_reg(CFG_COLORS_LOW, {$urandom, $urandom});
            write_reg(CFG_COLORS_HIGH, {$urandom, $urandom});
            @(negedge i_clk);
            repeat (PHASE_ITEMS) pending_samples.push_back(pick_sample());
            wait_drained();
        end

        repeat (LATENCY + 4) @(posedge i_clk);
        $display("Summary: %0d samples colored over %0d gradient settings", colors_seen,
                 settings_used);
        $display("Summary: stop counts 0 to 7, tied and unsorted stops, long output stall");
        if (mismatches == 0) begin
            $display("color_gradient_lookup_tb: PASS");
        end else begin
            $display("color_gradient_lookup_tb: FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/cgl_pkg.sv
hdl/cgl_seg.sv
hdl/cgl_blend.sv
hdl/cgl_div.sv
hdl/color_gradient_lookup.sv
verif/color_gradient_lookup_tb.sv
